### rtl/temperature_alarm_with_serial_setpoints_top_macros.svh
// Assertion macros shared by the temperature alarm RTL.
`ifndef TEMPERATURE_ALARM_WITH_SERIAL_SETPOINTS_TOP_MACROS_SVH
`define TEMPERATURE_ALARM_WITH_SERIAL_SETPOINTS_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TMPAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TMPAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tmpal_pkg.sv
// Shared types, codes and constants of the temperature alarm.
package tmpal_pkg;

    // Parameter defaults.
    localparam int REPORT_TICKS_DEF = 5;
    localparam int ADC_BITS_DEF     = 12;

    // Field widths fixed by the interface.
    localparam int TEMP_W  = 9;
    localparam int VALUE_W = 16;
    localparam int DUTY_W  = 7;
    localparam int BYTE_W  = 8;

    // Scaling and parsing constants.
    localparam logic [TEMP_W-1:0]  FULL_SCALE_DEG = 9'd330;
    localparam logic [VALUE_W-1:0] ASCII_ZERO     = 16'd48;
    localparam logic [VALUE_W-1:0] DUTY_MAX       = 16'd100;
    localparam logic [VALUE_W-1:0] LOW_THR_RESET  = 16'd100;
    localparam logic [VALUE_W-1:0] HIGH_THR_RESET = 16'd200;

    // Command letters.
    localparam logic [BYTE_W-1:0] CHAR_Q = 8'h71;
    localparam logic [BYTE_W-1:0] CHAR_W = 8'h77;
    localparam logic [BYTE_W-1:0] CHAR_X = 8'h78;
    localparam logic [BYTE_W-1:0] CHAR_N = 8'h6E;

    typedef enum logic {
        EV_TICK = 1'b0,
        EV_BYTE = 1'b1
    } t_event;

    typedef enum logic [1:0] {
        LVL_WITHIN  = 2'd0,
        LVL_BELOW   = 2'd1,
        LVL_ABOVE   = 2'd2,
        LVL_NO_TICK = 2'd3
    } t_level;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_DUTY_Q   = 3'd1,
        CMD_DUTY_W   = 3'd2,
        CMD_REJECTED = 3'd3,
        CMD_HIGH_SET = 3'd4,
        CMD_LOW_SET  = 3'd5
    } t_cmd_code;

    // Outcome of one serial byte, with the state it leaves behind.
    typedef struct packed {
        t_cmd_code          code;
        logic [VALUE_W-1:0] value;
        logic [DUTY_W-1:0]  duty;
        logic               ind;
    } t_cmd_res;

endpackage

### rtl/tmpal_scale.sv
// Converts a raw converter reading to whole degrees.
module tmpal_scale
    import tmpal_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic [ADC_BITS-1:0] i_sample,
    output logic [TEMP_W-1:0]   o_temperature
);

    localparam int PROD_W = ADC_BITS + TEMP_W;
    localparam int REM_W  = ADC_BITS + 2;
    localparam logic [REM_W-1:0] FULL_CODE  = REM_W'((1 << ADC_BITS) - 1);
    localparam logic [REM_W-1:0] FULL_CODE2 = REM_W'(2 * ((1 << ADC_BITS) - 1));

    logic [PROD_W-1:0] product;
    logic [TEMP_W-1:0] quot_hi;
    logic [REM_W-1:0]  rem_sum;
    logic [1:0]        quot_fix;

    // Divide by (2^N - 1): p = q0*2^N + m gives p/(2^N-1) = q0 + (q0+m)/(2^N-1),
    // and the second term is below three, so two compares finish it.
    always_comb begin
        product  = PROD_W'(i_sample) * PROD_W'(FULL_SCALE_DEG);
        quot_hi  = product[PROD_W-1:ADC_BITS];
        rem_sum  = REM_W'(product[ADC_BITS-1:0]) + REM_W'(quot_hi);
        if (rem_sum >= FULL_CODE2) begin
            quot_fix = 2'd2;
        end else if (rem_sum >= FULL_CODE) begin
            quot_fix = 2'd1;
        end else begin
            quot_fix = 2'd0;
        end
        o_temperature = quot_hi + TEMP_W'(quot_fix);
    end

endmodule

### rtl/tmpal_cmd.sv
// Serial command parser holding the accumulator, thresholds, duty and indicator.
module tmpal_cmd
    import tmpal_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_update,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    output t_cmd_res           o_res,
    output logic [VALUE_W-1:0] o_low_thr,
    output logic [VALUE_W-1:0] o_high_thr
);

    logic [VALUE_W-1:0] r_acc,  n_acc;
    logic [VALUE_W-1:0] r_low,  n_low;
    logic [VALUE_W-1:0] r_high, n_high;
    logic [DUTY_W-1:0]  r_duty, n_duty;
    logic               r_ind,  n_ind;
    logic [VALUE_W-1:0] acc_times10;

    // Decode the byte and work out the state it leaves.
    always_comb begin
        acc_times10 = (r_acc << 3) + (r_acc << 1);
        n_acc       = '0;
        n_low       = r_low;
        n_high      = r_high;
        n_duty      = r_duty;
        n_ind       = r_ind;
        o_res.code  = CMD_NONE;
        o_res.value = '0;
        case (i_rx_byte)
            CHAR_Q, CHAR_W: begin
                o_res.value = r_acc;
                if (r_acc <= DUTY_MAX) begin
                    n_duty     = r_acc[DUTY_W-1:0];
                    o_res.code = (i_rx_byte == CHAR_Q) ? CMD_DUTY_Q : CMD_DUTY_W;
                end else begin
                    o_res.code = CMD_REJECTED;
                end
            end
            CHAR_X: begin
                n_ind       = ~r_ind;
                n_high      = r_acc;
                o_res.value = r_acc;
                o_res.code  = CMD_HIGH_SET;
            end
            CHAR_N: begin
                n_low       = r_acc;
                o_res.value = r_acc;
                o_res.code  = CMD_LOW_SET;
            end
            default: begin
                // Any other byte is folded in as a digit, wrapping at 16 bits.
                n_acc = acc_times10 + VALUE_W'(i_rx_byte) - ASCII_ZERO;
            end
        endcase
        // A tick item leaves duty and indicator as they are, whatever its byte field holds.
        o_res.duty = i_update ? n_duty : r_duty;
        o_res.ind  = i_update ? n_ind : r_ind;
    end

    // Commit the new state when the byte item moves to the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_low  <= LOW_THR_RESET;
            r_high <= HIGH_THR_RESET;
            r_duty <= '0;
            r_ind  <= 1'b0;
        end else if (i_update) begin
            r_acc  <= n_acc;
            r_low  <= n_low;
            r_high <= n_high;
            r_duty <= n_duty;
            r_ind  <= n_ind;
        end
    end

    assign o_low_thr  = r_low;
    assign o_high_thr = r_high;

endmodule

### rtl/temperature_alarm_with_serial_setpoints_top.sv
// Top level of the temperature alarm with serial setpoints.
//
//  Channel | Direction | Handshake                    | Payload
//  --------+-----------+------------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall      | i_cmd, i_adc_sample, i_rx_byte
//  out     | output    | o_out_valid / i_out_stall    | o_level, o_temperature, o_report_due,
//          |           |                              | o_cmd_result, o_cmd_value,
//          |           |                              | o_duty_out, o_indicator
//
// One item per cycle sustained while the output is not stalled; an item sits in the input register
// after its accepting edge and then in the result register, with the scaling and command decode between.
// Reset is synchronous and active low; it clears the valids, tick count and parser state.
// A stall on the output holds the result register and then the input register; o_in_stall
// rises only while both registers are full.
module temperature_alarm_with_serial_setpoints_top
    import tmpal_pkg::*;
#(
    parameter int REPORT_TICKS = REPORT_TICKS_DEF,
    parameter int ADC_BITS     = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic [ADC_BITS-1:0] i_adc_sample,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_level,
    output logic [TEMP_W-1:0]   o_temperature,
    output logic                o_report_due,
    output logic [2:0]          o_cmd_result,
    output logic [VALUE_W-1:0]  o_cmd_value,
    output logic [DUTY_W-1:0]   o_duty_out,
    output logic                o_indicator
);

    `include "temperature_alarm_with_serial_setpoints_top_macros.svh"

    localparam int CNT_W = (REPORT_TICKS > 1) ? $clog2(REPORT_TICKS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REPORT_TICKS - 1);

    // Input register.
    logic                r_in_valid;
    t_event              r_in_cmd;
    logic [ADC_BITS-1:0] r_in_sample;
    logic [BYTE_W-1:0]   r_in_byte;

    // Result register.
    logic                r_out_valid;
    t_level              r_level;
    logic [TEMP_W-1:0]   r_temperature;
    logic                r_report;
    t_cmd_code           r_cmd_result;
    logic [VALUE_W-1:0]  r_cmd_value;
    logic [DUTY_W-1:0]   r_duty;
    logic                r_ind;

    logic [CNT_W-1:0]    r_tick_cnt, n_tick_cnt;

    logic                advance;
    logic                fire;
    logic                byte_update;
    logic [TEMP_W-1:0]   temp_scaled;
    t_cmd_res            cmd_res;
    logic [VALUE_W-1:0]  low_thr;
    logic [VALUE_W-1:0]  high_thr;

    t_level              n_level;
    logic [TEMP_W-1:0]   n_temperature;
    logic                n_report;
    t_cmd_code           n_cmd_result;
    logic [VALUE_W-1:0]  n_cmd_value;

    // Pipeline flow control.
    assign advance     = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && advance;
    assign byte_update = fire && (r_in_cmd == EV_BYTE);
    assign o_in_stall  = r_in_valid && !advance;

    tmpal_scale #(
        .ADC_BITS (ADC_BITS)
    ) u_scale (
        .i_sample      (r_in_sample),
        .o_temperature (temp_scaled)
    );

    tmpal_cmd u_cmd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_update   (byte_update),
        .i_rx_byte  (r_in_byte),
        .o_res      (cmd_res),
        .o_low_thr  (low_thr),
        .o_high_thr (high_thr)
    );

    // Result fields for the item in the input register.
    always_comb begin
        n_level       = LVL_NO_TICK;
        n_temperature = '0;
        n_report      = 1'b0;
        n_cmd_result  = CMD_NONE;
        n_cmd_value   = '0;
        n_tick_cnt    = r_tick_cnt;
        if (r_in_cmd == EV_TICK) begin
            n_temperature = temp_scaled;
            if (VALUE_W'(temp_scaled) < low_thr) begin
                n_level = LVL_BELOW;
            end else if (VALUE_W'(temp_scaled) > high_thr) begin
                n_level = LVL_ABOVE;
            end else begin
                n_level = LVL_WITHIN;
            end
            if (r_tick_cnt == CNT_LAST) begin
                n_report   = 1'b1;
                n_tick_cnt = '0;
            end else begin
                n_tick_cnt = r_tick_cnt + 1'b1;
            end
        end else begin
            n_cmd_result = cmd_res.code;
            n_cmd_value  = cmd_res.value;
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_cmd    <= t_event'(i_cmd);
            r_in_sample <= i_adc_sample;
            r_in_byte   <= i_rx_byte;
        end
    end

    // Result valid and tick counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tick_cnt  <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_tick_cnt <= n_tick_cnt;
            end
        end
    end

    // Result payload; duty and indicator also show their value after a tick.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_level       <= n_level;
            r_temperature <= n_temperature;
            r_report      <= n_report;
            r_cmd_result  <= n_cmd_result;
            r_cmd_value   <= n_cmd_value;
            r_duty        <= cmd_res.duty;
            r_ind         <= cmd_res.ind;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_level       = r_level;
    assign o_temperature = r_temperature;
    assign o_report_due  = r_report;
    assign o_cmd_result  = r_cmd_result;
    assign o_cmd_value   = r_cmd_value;
    assign o_duty_out    = r_duty;
    assign o_indicator   = r_ind;

    // The input side is held only while both registers are full and the output is stalled.
    `TMPAL_ASSERT_NOW(a_stall_cause, o_in_stall, r_out_valid && i_out_stall && r_in_valid, "input stall without full pipeline")
    // A byte item carries no temperature or report.
    `TMPAL_ASSERT_NOW(a_byte_fields, r_out_valid && r_level == LVL_NO_TICK, r_temperature == '0 && !r_report, "byte item with tick fields")
    // A tick item carries no command outcome.
    `TMPAL_ASSERT_NOW(a_tick_fields, r_out_valid && r_level != LVL_NO_TICK, r_cmd_result == CMD_NONE && r_cmd_value == '0, "tick item with command fields")
    // Scaled temperature and applied duty stay within range.
    `TMPAL_ASSERT_NOW(a_ranges, r_out_valid, r_temperature <= FULL_SCALE_DEG && VALUE_W'(r_duty) <= DUTY_MAX, "result field out of range")
    // A duty that was not applied leaves the shown duty unchanged from the prior result.
    `TMPAL_ASSERT_NEXT(a_reject_hold, fire && r_in_cmd == EV_BYTE && cmd_res.code == CMD_REJECTED, r_duty == $past(cmd_res.duty), "rejected duty changed output")

endmodule

### tb/alarm_checker.sv
// Checker that predicts and compares every result of the temperature alarm.
module alarm_checker
    import tmpal_pkg::*;
#(
    parameter int REPORT_TICKS = REPORT_TICKS_DEF,
    parameter int ADC_BITS     = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_cmd,
    input  logic [ADC_BITS-1:0] i_adc_sample,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [1:0]          i_level,
    input  logic [TEMP_W-1:0]   i_temperature,
    input  logic                i_report_due,
    input  logic [2:0]          i_cmd_result,
    input  logic [VALUE_W-1:0]  i_cmd_value,
    input  logic [DUTY_W-1:0]   i_duty_out,
    input  logic                i_indicator,
    output int                  o_mismatch_count,
    output int                  o_pending
);

    // One predicted result item.
    typedef struct {
        t_level             level;
        logic [TEMP_W-1:0]  temperature;
        logic               report_due;
        t_cmd_code          cmd_result;
        logic [VALUE_W-1:0] cmd_value;
        logic [DUTY_W-1:0]  duty;
        logic               indicator;
    } t_alarm_result;

    // Predicted state of the alarm.
    int unsigned        tick_cnt;
    logic [VALUE_W-1:0] low_thr;
    logic [VALUE_W-1:0] high_thr;
    logic [VALUE_W-1:0] digits;
    logic [DUTY_W-1:0]  duty;
    logic               lamp;

    t_alarm_result alarm_results[$];
    int            mismatches = 0;

    // Advances the predicted state by one event and returns the result it causes.
    function automatic t_alarm_result predict_alarm_result(
        input logic                cmd,
        input logic [ADC_BITS-1:0] sample,
        input logic [BYTE_W-1:0]   rx
    );
        t_alarm_result      r;
        logic [31:0]        scaled;
        logic [VALUE_W-1:0] acc;
        r = '{LVL_NO_TICK, '0, 1'b0, CMD_NONE, '0, '0, 1'b0};
        if (cmd == EV_TICK) begin
            // Scale the sample to degrees and classify it against the thresholds.
            scaled = (32'(sample) * 32'(FULL_SCALE_DEG)) / ((32'd1 << ADC_BITS) - 32'd1);
            r.temperature = scaled[TEMP_W-1:0];
            if (32'(r.temperature) < 32'(low_thr)) begin
                r.level = LVL_BELOW;
            end else if (32'(r.temperature) > 32'(high_thr)) begin
                r.level = LVL_ABOVE;
            end else begin
                r.level = LVL_WITHIN;
            end
            if (tick_cnt + 1 >= REPORT_TICKS) begin
                r.report_due = 1'b1;
                tick_cnt = 0;
            end else begin
                tick_cnt++;
            end
        end else begin
            // Command letters consume the accumulator; other bytes fold into it.
            acc = digits;
            case (rx)
                CHAR_Q, CHAR_W: begin
                    r.cmd_value = acc;
                    if (acc <= DUTY_MAX) begin
                        duty = acc[DUTY_W-1:0];
                        if (rx == CHAR_Q) begin
                            r.cmd_result = CMD_DUTY_Q;
                        end else begin
                            r.cmd_result = CMD_DUTY_W;
                        end
                    end else begin
                        r.cmd_result = CMD_REJECTED;
                    end
                    digits = '0;
                end
                CHAR_X: begin
                    lamp = ~lamp;
                    high_thr = acc;
                    r.cmd_value = acc;
                    r.cmd_result = CMD_HIGH_SET;
                    digits = '0;
                end
                CHAR_N: begin
                    low_thr = acc;
                    r.cmd_value = acc;
                    r.cmd_result = CMD_LOW_SET;
                    digits = '0;
                end
                default: begin
                    digits = acc * 16'd10 + {8'b0, rx} - ASCII_ZERO;
                end
            endcase
        end
        r.duty = duty;
        r.indicator = lamp;
        return r;
    endfunction

    // Reports one field that differs from its prediction.
    function automatic int field_mismatch(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Predict on every accepted input item, compare on every accepted result item.
    always @(posedge i_clk) begin : watch_channels
        t_alarm_result want;
        if (!i_rst_n) begin
            tick_cnt = 0;
            low_thr = LOW_THR_RESET;
            high_thr = HIGH_THR_RESET;
            digits = '0;
            duty = '0;
            lamp = 1'b0;
            alarm_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                alarm_results.push_back(predict_alarm_result(i_cmd, i_adc_sample, i_rx_byte));
            end
            if (i_out_valid && !i_out_stall) begin
                if (alarm_results.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    mismatches++;
                end else begin
                    want = alarm_results.pop_front();
                    mismatches += field_mismatch("level", want.level, i_level);
                    mismatches += field_mismatch("temperature", want.temperature,
                                                 i_temperature);
                    mismatches += field_mismatch("report_due", want.report_due,
                                                 i_report_due);
                    mismatches += field_mismatch("cmd_result", want.cmd_result,
                                                 i_cmd_result);
                    mismatches += field_mismatch("cmd_value", want.cmd_value, i_cmd_value);
                    mismatches += field_mismatch("duty_out", want.duty, i_duty_out);
                    mismatches += field_mismatch("indicator", want.indicator, i_indicator);
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_pending <= alarm_results.size();
    end

endmodule

### tb/testbench.sv
// Top of the temperature alarm testbench: clock, reset, stimulus and verdict.
module testbench;
    import tmpal_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int DIRECTED_ITEMS = 25;
    localparam int DRAIN_CYCLES   = 8;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    i_cmd        = 1'b0;
    logic [ADC_BITS_DEF-1:0] i_adc_sample = '0;
    logic [BYTE_W-1:0]       i_rx_byte    = '0;
    logic                    i_out_stall  = 1'b0;

    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [1:0]              o_level;
    logic [TEMP_W-1:0]       o_temperature;
    logic                    o_report_due;
    logic [2:0]              o_cmd_result;
    logic [VALUE_W-1:0]      o_cmd_value;
    logic [DUTY_W-1:0]       o_duty_out;
    logic                    o_indicator;

    int mismatch_count;
    int pending_count;
    int burst_left  = 0;
    int items_sent  = 0;

    temperature_alarm_with_serial_setpoints_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_adc_sample (i_adc_sample),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_level      (o_level),
        .o_temperature(o_temperature),
        .o_report_due (o_report_due),
        .o_cmd_result (o_cmd_result),
        .o_cmd_value  (o_cmd_value),
        .o_duty_out   (o_duty_out),
        .o_indicator  (o_indicator)
    );

    alarm_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_adc_sample    (i_adc_sample),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_level         (o_level),
        .i_temperature   (o_temperature),
        .i_report_due    (o_report_due),
        .i_cmd_result    (o_cmd_result),
        .i_cmd_value     (o_cmd_value),
        .i_duty_out      (o_duty_out),
        .i_indicator     (o_indicator),
        .o_mismatch_count(mismatch_count),
        .o_pending       (pending_count)
    );

    // Clock with a period of 12.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Offers one item, opening a new burst after a random gap when the last one ran out.
    task automatic offer_item(input logic cmd, input logic [ADC_BITS_DEF-1:0] sample,
                              input logic [BYTE_W-1:0] rx);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 10)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(100, 300);
            end else begin
                burst_left = $urandom_range(1, 20);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_adc_sample <= sample;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // The unused payload field of each event carries random bits.
    task automatic send_tick(input logic [ADC_BITS_DEF-1:0] sample);
        offer_item(EV_TICK, sample, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] rx);
        offer_item(EV_BYTE, ADC_BITS_DEF'($urandom_range(0, 4095)), rx);
    endtask

    // Sends a value as decimal digits followed by a command letter, with ticks mixed in when mix_ticks is set.
    task automatic send_command(input logic [BYTE_W-1:0] letter, input int unsigned value,
                                input bit mix_ticks);
        string digit_text;
        digit_text = $sformatf("%0d", value);
        for (int i = 0; i < digit_text.len(); i++) begin
            if (mix_ticks && $urandom_range(0, 4) == 0) begin
                send_tick(ADC_BITS_DEF'($urandom_range(0, 4095)));
            end
            send_byte(digit_text[i]);
        end
        send_byte(letter);
    endtask

    // Receiver stalls in segments of differing density, with long hold-offs now and then.
    initial begin : receiver
        int seg;
        int mode;
        int n;
        seg = 0;
        forever begin
            if (seg == 3 || seg % 20 == 11) begin
                // Long hold-off so the block fills and stalls its input.
                n = 0;
                while (n < 120) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                    n++;
                end
            end else begin
                mode = $urandom_range(0, 3);
                repeat ($urandom_range(20, 200)) begin
                    @(negedge i_clk);
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= ($urandom_range(0, 3) == 0);
                        2: i_out_stall <= ($urandom_range(0, 3) != 0);
                        default: i_out_stall <= ~i_out_stall;
                    endcase
                end
            end
            seg++;
        end
    end

    // Ends the run when neither channel accepts anything for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("testbench failed");
        $finish;
    end

    // Reset, directed items, random items, drain and verdict.
    initial begin : stimulus
        int                pick;
        int unsigned       value;
        logic [BYTE_W-1:0] letter;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Temperature extremes and the exact threshold boundaries.
        send_tick(ADC_BITS_DEF'(0));
        send_tick(ADC_BITS_DEF'(4095));
        send_tick(ADC_BITS_DEF'(1241));
        send_tick(ADC_BITS_DEF'(2482));
        // Duty letter with an empty accumulator, the largest duty, and a rejected one.
        send_byte(CHAR_Q);
        send_command(CHAR_W, 100, 0);
        send_command(CHAR_Q, 101, 0);
        // Largest high threshold, then a full-scale tick lands within.
        send_command(CHAR_X, 65535, 0);
        send_tick(ADC_BITS_DEF'(4095));
        // Zero low threshold, non-digit bytes folded in, then applied as high threshold.
        send_byte(CHAR_N);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CHAR_X);
        send_tick(ADC_BITS_DEF'(0));

        // Mostly well-formed commands with random values, ticks and some noise bytes.
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_tick($urandom_range(0, 1) ? ADC_BITS_DEF'(4095) : ADC_BITS_DEF'(0));
                end else begin
                    send_tick(ADC_BITS_DEF'($urandom_range(0, 4095)));
                end
            end else if (pick < 88) begin
                case ($urandom_range(0, 3))
                    0: letter = CHAR_Q;
                    1: letter = CHAR_W;
                    2: letter = CHAR_X;
                    default: letter = CHAR_N;
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    // Long digit strings wrap the accumulator.
                    value = $urandom_range(0, 9999999);
                end else if (letter == CHAR_Q || letter == CHAR_W) begin
                    value = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 100)
                                                       : $urandom_range(95, 300);
                end else if (letter == CHAR_X) begin
                    value = $urandom_range(100, 340);
                end else begin
                    value = $urandom_range(0, 230);
                end
                send_command(letter, value, 1);
            end else begin
                send_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end

        // Drain: wait for every predicted result, then let the pipeline settle before the verdict.
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
